>>> rtl/core/assert_macros.svh
// -----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the framer checker.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked on clk, quiet while arst_n is low.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked on clk, also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> rtl/core/ecpf_pkg.sv
// -----------------------------------------------------------------------------
// ecpf_pkg
// Types, constants and helpers shared by the escaped checksum packet framer.
// -----------------------------------------------------------------------------
package ecpf_pkg;

	localparam int BYTE_W      = 8;
	localparam int MAX_BURST   = 6;
	localparam int IDX_W       = 3;
	localparam int APB_ADDR_W  = 5;
	localparam int APB_DATA_W  = 32;

	localparam logic [BYTE_W-1:0] RST_START_CODE  = 8'd141;
	localparam logic [BYTE_W-1:0] RST_END_CODE    = 8'd216;
	localparam logic [BYTE_W-1:0] RST_ESCAPE_CODE = 8'd171;
	localparam logic [BYTE_W-1:0] RST_START_SUB   = 8'd5;
	localparam logic [BYTE_W-1:0] RST_END_SUB     = 8'd80;
	localparam logic [BYTE_W-1:0] RST_ESCAPE_SUB  = 8'd35;

	typedef enum logic [2:0] {
		REG_START_CODE  = 3'd0,
		REG_END_CODE    = 3'd1,
		REG_ESCAPE_CODE = 3'd2,
		REG_START_SUB   = 3'd3,
		REG_END_SUB     = 3'd4,
		REG_ESCAPE_SUB  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [BYTE_W-1:0] payload_byte;
		logic              carries_byte;
		logic              packet_last;
	} in_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              run_last;
		logic              frame_done;
	} out_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_code;
		logic [BYTE_W-1:0] end_code;
		logic [BYTE_W-1:0] escape_code;
		logic [BYTE_W-1:0] start_substitute;
		logic [BYTE_W-1:0] end_substitute;
		logic [BYTE_W-1:0] escape_substitute;
	} codes_t;

	typedef struct packed {
		logic              hit;
		logic [BYTE_W-1:0] sub;
	} esc_t;

	// Priority: start, then end, then escape.
	function automatic esc_t escape_lookup(input logic [BYTE_W-1:0] b, input codes_t c);
		esc_t r;
		r.hit = 1'b1;
		if (b == c.start_code) begin
			r.sub = c.start_substitute;
		end else if (b == c.end_code) begin
			r.sub = c.end_substitute;
		end else if (b == c.escape_code) begin
			r.sub = c.escape_substitute;
		end else begin
			r.hit = 1'b0;
			r.sub = b;
		end
		return r;
	endfunction

endpackage

>>> rtl/core/escaped_checksum_packet_framer.sv
// -----------------------------------------------------------------------------
// escaped_checksum_packet_framer
// Byte-stuffing packet framer with an inverted 8-bit sum checksum.
// -----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready/in_data): one payload transaction per
//    item. carries_byte=0 with packet_last=0 is consumed and produces nothing.
//  - Output channel (out_valid/out_ready/out_data): one framed byte per cycle
//    while out_ready is high. run_last marks the final byte caused by an item,
//    frame_done the end code. An item expands to 1..6 bytes: optional start
//    code, payload byte (escaped to two bytes if it matches a code), and on
//    packet_last the escaped inverted sum followed by the end code.
//  - First byte of an item is on out_data in the cycle after acceptance.
//  - An item stays in the burst register until its last byte is taken; the
//    next item can be taken in the same cycle the last byte of the current
//    burst is taken, so the output need not idle between items.
//  - Receiver stall: the burst register holds; in_ready drops until the final
//    byte of the burst is taken.
//  - Reset: no packet open, sum cleared, codes back to their defaults, output
//    empty.
//  - APB: six 8-bit code registers at 4*i; pready is tied high.
// -----------------------------------------------------------------------------
module escaped_checksum_packet_framer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  ecpf_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output ecpf_pkg::out_item_t                 out_data,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ecpf_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [ecpf_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [ecpf_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready
);
	import ecpf_pkg::*;

	// Code registers
	codes_t   codes_q;
	reg_idx_t reg_sel;
	logic     cfg_wr;

	// Packet state
	logic              inside_q;
	logic [BYTE_W-1:0] sum_q;

	// Burst (result) register
	logic [BYTE_W-1:0] burst_s1 [MAX_BURST];
	logic [IDX_W-1:0]  cnt_s1;
	logic              last_s1;
	logic              valid_s1;
	logic [IDX_W-1:0]  idx_q;

	// Burst build
	logic [BYTE_W-1:0] burst_d [MAX_BURST];
	logic [IDX_W-1:0]  n;
	logic              active;
	logic [BYTE_W-1:0] sum_base;
	logic [BYTE_W-1:0] sum_new;
	esc_t              pay_esc;
	esc_t              ck_esc;

	logic is_final;
	logic take;
	logic accept;

	// ---------------------------------------------------------------- APB
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		prdata = '0;
		case (reg_sel)
			REG_START_CODE:  prdata[BYTE_W-1:0] = codes_q.start_code;
			REG_END_CODE:    prdata[BYTE_W-1:0] = codes_q.end_code;
			REG_ESCAPE_CODE: prdata[BYTE_W-1:0] = codes_q.escape_code;
			REG_START_SUB:   prdata[BYTE_W-1:0] = codes_q.start_substitute;
			REG_END_SUB:     prdata[BYTE_W-1:0] = codes_q.end_substitute;
			REG_ESCAPE_SUB:  prdata[BYTE_W-1:0] = codes_q.escape_substitute;
			default:         prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			codes_q.start_code        <= RST_START_CODE;
			codes_q.end_code          <= RST_END_CODE;
			codes_q.escape_code       <= RST_ESCAPE_CODE;
			codes_q.start_substitute  <= RST_START_SUB;
			codes_q.end_substitute    <= RST_END_SUB;
			codes_q.escape_substitute <= RST_ESCAPE_SUB;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_START_CODE:  codes_q.start_code        <= pwdata[BYTE_W-1:0];
				REG_END_CODE:    codes_q.end_code          <= pwdata[BYTE_W-1:0];
				REG_ESCAPE_CODE: codes_q.escape_code       <= pwdata[BYTE_W-1:0];
				REG_START_SUB:   codes_q.start_substitute  <= pwdata[BYTE_W-1:0];
				REG_END_SUB:     codes_q.end_substitute    <= pwdata[BYTE_W-1:0];
				REG_ESCAPE_SUB:  codes_q.escape_substitute <= pwdata[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------- build
	// Sum restarts when no packet is open; the checksum covers this byte too.
	assign active   = in_data.carries_byte | in_data.packet_last;
	assign sum_base = inside_q ? sum_q : '0;
	assign sum_new  = sum_base + (in_data.carries_byte ? in_data.payload_byte : '0);
	assign pay_esc  = escape_lookup(in_data.payload_byte, codes_q);
	assign ck_esc   = escape_lookup(~sum_new, codes_q);

	// Append bytes in frame order; at most six positions.
	always_comb begin
		for (int i = 0; i < MAX_BURST; i++) begin
			burst_d[i] = '0;
		end
		n = '0;
		if (active) begin
			if (!inside_q) begin
				burst_d[n] = codes_q.start_code;
				n = n + 3'd1;
			end
			if (in_data.carries_byte) begin
				if (pay_esc.hit) begin
					burst_d[n]        = codes_q.escape_code;
					burst_d[n + 3'd1] = pay_esc.sub;
					n = n + 3'd2;
				end else begin
					burst_d[n] = in_data.payload_byte;
					n = n + 3'd1;
				end
			end
			if (in_data.packet_last) begin
				if (ck_esc.hit) begin
					burst_d[n]        = codes_q.escape_code;
					burst_d[n + 3'd1] = ck_esc.sub;
					n = n + 3'd2;
				end else begin
					burst_d[n] = ~sum_new;
					n = n + 3'd1;
				end
				burst_d[n] = codes_q.end_code;
				n = n + 3'd1;
			end
		end
	end

	// ---------------------------------------------------------------- handshake
	assign is_final = (idx_q == cnt_s1 - 3'd1);
	assign take     = valid_s1 & out_ready;
	// Free when empty, or when the closing byte of the burst leaves now.
	assign in_ready = ~valid_s1 | (out_ready & is_final);
	assign accept   = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			sum_q    <= '0;
		end else if (accept && active) begin
			if (in_data.packet_last) begin
				inside_q <= 1'b0;
				sum_q    <= '0;
			end else begin
				inside_q <= 1'b1;
				sum_q    <= sum_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (accept && active) begin
			valid_s1 <= 1'b1;
			idx_q    <= '0;
		end else if (take) begin
			if (is_final) begin
				valid_s1 <= 1'b0;
				idx_q    <= '0;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && active) begin
			burst_s1 <= burst_d;
			cnt_s1   <= n;
			last_s1  <= in_data.packet_last;
		end
	end

	// ---------------------------------------------------------------- output
	assign out_valid           = valid_s1;
	assign out_data.out_byte   = burst_s1[idx_q];
	assign out_data.run_last   = is_final;
	assign out_data.frame_done = is_final & last_s1;

endmodule

>>> rtl/core/ecpf_checker.sv
// -----------------------------------------------------------------------------
// ecpf_checker
// Port-level checks for the framer, bound to the top level.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module ecpf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input ecpf_pkg::in_item_t              in_data,
	input logic                            out_valid,
	input logic                            out_ready,
	input ecpf_pkg::out_item_t             out_data,
	input logic                            pready
);
	import ecpf_pkg::*;

	// A stalled byte holds.
	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "output changed while stalled")

	// The end code is always the closing byte of its item.
	`ASSERT_CLK(a_done_last, out_valid && out_data.frame_done |-> out_data.run_last, "frame_done without run_last")

	// An item that frames something shows a byte next cycle.
	`ASSERT_CLK(a_emit, in_valid && in_ready && (in_data.carries_byte || in_data.packet_last) |=> out_valid, "accepted item produced no byte")

	// A stalled output blocks intake.
	`ASSERT_CLK(a_stall_block, out_valid && !out_ready |-> !in_ready, "input taken while output stalled")

	`ASSERT_ALWAYS(a_pready, pready, "pready dropped")

endmodule

bind escaped_checksum_packet_framer ecpf_checker u_ecpf_checker (.*);
